// File: hw/rtl/cte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// shared types, codes and widths of the character tokenizer and evaluator
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam int CHAR_W     = 8;
  localparam int NUM_W      = 32;
  localparam int TEXT_BYTES = 8;
  localparam int TEXT_W     = TEXT_BYTES * CHAR_W;
  localparam int LEN_W      = 4;
  localparam int KIND_W     = 3;
  localparam int MAX_TEXT   = 8;
  localparam int OUT_FIELDS_W = NUM_W + TEXT_W + LEN_W + NUM_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;

  // answer when no operator expression was found
  localparam logic [NUM_W-1:0] NO_EXPR_ANSWER = 32'd999;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER = 3'd0,
    KIND_SYMBOL = 3'd1,
    KIND_TEXT   = 3'd2,
    KIND_PLUS   = 3'd3,
    KIND_MINUS  = 3'd4,
    KIND_MUL    = 3'd5,
    KIND_DIV    = 3'd6,
    KIND_ANSWER = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_TEXT = 2'd2
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input transaction
    logic emit_run;   // send the open run token and close the run
    logic emit_char;  // send the operator or symbol token
    logic absorb;     // add the character to its run
    logic eval;       // compute the answer, start the divider if needed
    logic div_take;   // take the signed quotient
    logic emit_ans;   // send the answer and clear the expression state
  } cte_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_needed; // a run is open and the character does not extend it
    logic char_token;   // the character is an operator or symbol
    logic end_seen;     // the character was the last of the expression
    logic run_open;
    logic need_div;
    logic div_busy;
    logic out_free;     // output register can take a result this cycle
  } cte_stat_t;

endpackage

// File: hw/rtl/cte_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cte_div
  import cte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] d_r;

  logic [NUM_W:0]   rem_sh;
  logic [NUM_W:0]   diff;
  logic             q_bit;

  assign rem_sh = {rem_r, q_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign q_bit  = ~diff[NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], q_bit};
      rem_r <= q_bit ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// File: hw/rtl/cte_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_dp
// run state, token bookkeeping, evaluator and output register
// ----------------------------------------------------------------------------
module cte_dp
  import cte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cte_cmd_t              cmd,
  output cte_stat_t             stat,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic                  in_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [NUM_W-1:0]      out_num,
  output logic [TEXT_W-1:0]     out_text,
  output logic [LEN_W-1:0]      out_len,
  output logic [NUM_W-1:0]      out_answer,
  output logic                  out_err,
  output logic                  out_last
);

  // captured input
  logic [CHAR_W-1:0] char_r;
  logic              end_r;

  // run and expression state
  mode_t             mode_r;
  logic [NUM_W-1:0]  accum_r;
  logic [TEXT_W-1:0] buf_r;
  logic [LEN_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [1:0]        tokens_r;
  logic [NUM_W-1:0]  left_r;
  kind_t             op_r;
  logic [NUM_W-1:0]  right_r;

  // answer
  logic [NUM_W-1:0]  ans_r;
  logic              err_r;
  logic              div_neg_r;

  // output register
  logic              out_valid_r;
  logic [KIND_W-1:0] o_kind_r;
  logic [NUM_W-1:0]  o_num_r;
  logic [TEXT_W-1:0] o_text_r;
  logic [LEN_W-1:0]  o_len_r;
  logic [NUM_W-1:0]  o_ans_r;
  logic              o_err_r;
  logic              o_last_r;

  mode_t             cls;
  kind_t             char_kind;
  logic              out_free;
  logic              tok_load;
  logic              tok_count;
  kind_t             tok_kind;
  logic [NUM_W-1:0]  tok_num;
  logic [TEXT_W-1:0] tok_text;
  logic [LEN_W-1:0]  tok_len;
  logic [NUM_W-1:0]  tok_ans;
  logic              tok_err;
  logic              tok_last;

  logic [NUM_W-1:0]  accum_base;
  logic [NUM_W-1:0]  digit;
  logic [TEXT_W-1:0] buf_base;
  logic [LEN_W-1:0]  cnt_base;
  logic [TEXT_W-1:0] buf_nxt;

  logic              left_neg;
  logic              right_neg;
  logic [NUM_W-1:0]  left_mag;
  logic [NUM_W-1:0]  right_mag;
  logic              expr_full;
  logic              div_start;
  logic [NUM_W-1:0]  quot;
  logic              div_busy;

  // character class and token kind
  always_comb begin
    if (char_r >= CH_ZERO && char_r <= CH_NINE) begin
      cls = MODE_NUM;
    end else if ((char_r >= CH_LO_A && char_r <= CH_LO_Z) ||
                 (char_r >= CH_UP_A && char_r <= CH_UP_Z)) begin
      cls = MODE_TEXT;
    end else begin
      cls = MODE_IDLE;
    end
    priority if (char_r == CH_PLUS)  char_kind = KIND_PLUS;
    else if (char_r == CH_MINUS)     char_kind = KIND_MINUS;
    else if (char_r == CH_STAR)      char_kind = KIND_MUL;
    else if (char_r == CH_SLASH)     char_kind = KIND_DIV;
    else                             char_kind = KIND_SYMBOL;
  end

  assign out_free  = ~out_valid_r | out_ready;
  assign expr_full = (tokens_r == 2'd3);

  assign stat.close_needed = (mode_r != MODE_IDLE) && (mode_r != cls);
  assign stat.char_token   = (cls == MODE_IDLE);
  assign stat.end_seen     = end_r;
  assign stat.run_open     = (mode_r != MODE_IDLE);
  assign stat.need_div     = expr_full && (op_r == KIND_DIV) && (right_r != '0);
  assign stat.div_busy     = div_busy;
  assign stat.out_free     = out_free;

  // result selection
  assign tok_load  = cmd.emit_run | cmd.emit_char | cmd.emit_ans;
  assign tok_count = cmd.emit_run | cmd.emit_char;

  always_comb begin
    tok_kind = KIND_SYMBOL;
    tok_num  = '0;
    tok_text = '0;
    tok_len  = '0;
    tok_ans  = '0;
    tok_err  = 1'b0;
    tok_last = 1'b0;
    if (cmd.emit_ans) begin
      tok_kind = KIND_ANSWER;
      tok_ans  = ans_r;
      tok_err  = err_r;
      tok_last = 1'b1;
    end else if (cmd.emit_run) begin
      if (mode_r == MODE_NUM) begin
        tok_kind = KIND_NUMBER;
        tok_num  = accum_r;
      end else begin
        tok_kind = KIND_TEXT;
        tok_text = buf_r;
        tok_len  = cnt_r;
        tok_err  = ovf_r;
      end
    end else begin
      tok_kind = char_kind;
      tok_text = {{(TEXT_W-CHAR_W){1'b0}}, char_r};
      tok_len  = LEN_W'(1);
    end
  end

  // run accumulation
  assign accum_base = (mode_r == MODE_NUM) ? accum_r : '0;
  assign digit      = NUM_W'(char_r - CH_ZERO);
  assign buf_base   = (mode_r == MODE_TEXT) ? buf_r : '0;
  assign cnt_base   = (mode_r == MODE_TEXT) ? cnt_r : '0;

  always_comb begin
    buf_nxt = buf_base;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      if (cnt_base == LEN_W'(i)) begin
        buf_nxt[i*CHAR_W +: CHAR_W] = char_r;
      end
    end
  end

  // operand magnitudes for the divider
  assign left_neg  = left_r[NUM_W-1];
  assign right_neg = right_r[NUM_W-1];
  assign left_mag  = left_neg  ? (NUM_W'(0) - left_r)  : left_r;
  assign right_mag = right_neg ? (NUM_W'(0) - right_r) : right_r;
  assign div_start = cmd.eval & stat.need_div;

  cte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (left_mag),
    .divisor  (right_mag),
    .busy     (div_busy),
    .quotient (quot)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      tokens_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tok_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (tok_count && tokens_r != 2'd3) begin
        tokens_r <= tokens_r + 2'd1;
      end
      if (cmd.emit_run) begin
        mode_r <= MODE_IDLE;
      end
      if (cmd.absorb) begin
        mode_r <= cls;
      end
      if (cmd.emit_ans) begin
        mode_r   <= MODE_IDLE;
        tokens_r <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char;
      end_r  <= in_end;
    end
    if (cmd.absorb) begin
      unique case (cls)
        MODE_NUM: begin
          accum_r <= (accum_base << 3) + (accum_base << 1) + digit;
        end
        MODE_TEXT: begin
          if (cnt_base < LEN_W'(MAX_TEXT)) begin
            buf_r <= buf_nxt;
            cnt_r <= cnt_base + LEN_W'(1);
            ovf_r <= (mode_r == MODE_TEXT) ? ovf_r : 1'b0;
          end else begin
            buf_r <= buf_base;
            cnt_r <= cnt_base;
            ovf_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (tok_count) begin
      unique case (tokens_r)
        2'd0:    left_r  <= tok_num;
        2'd1:    op_r    <= tok_kind;
        2'd2:    right_r <= tok_num;
        default: begin
        end
      endcase
    end
    if (cmd.eval) begin
      ans_r     <= NO_EXPR_ANSWER;
      err_r     <= 1'b0;
      div_neg_r <= left_neg ^ right_neg;
      if (expr_full) begin
        unique case (op_r)
          KIND_PLUS:  ans_r <= left_r + right_r;
          KIND_MINUS: ans_r <= left_r - right_r;
          KIND_MUL:   ans_r <= NUM_W'(left_r * right_r);
          KIND_DIV: begin
            ans_r <= '0;
            err_r <= (right_r == '0);
          end
          default:    ans_r <= NO_EXPR_ANSWER;
        endcase
      end
    end
    if (cmd.div_take) begin
      ans_r <= div_neg_r ? (NUM_W'(0) - quot) : quot;
    end
    if (tok_load) begin
      o_kind_r <= tok_kind;
      o_num_r  <= tok_num;
      o_text_r <= tok_text;
      o_len_r  <= tok_len;
      o_ans_r  <= tok_ans;
      o_err_r  <= tok_err;
      o_last_r <= tok_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = o_kind_r;
  assign out_num    = o_num_r;
  assign out_text   = o_text_r;
  assign out_len    = o_len_r;
  assign out_answer = o_ans_r;
  assign out_err    = o_err_r;
  assign out_last   = o_last_r;

endmodule

// File: hw/rtl/cte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_ctrl
// sequencer for one character: close run, token, end handling, answer
// ----------------------------------------------------------------------------
module cte_ctrl
  import cte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cte_stat_t stat,
  output cte_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_BODY,
    S_END_CLOSE,
    S_EVAL,
    S_DIV,
    S_ANS
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (!stat.close_needed) begin
          state_nxt = S_BODY;
        end else if (stat.out_free) begin
          cmd.emit_run = 1'b1;
          state_nxt    = S_BODY;
        end
      end
      S_BODY: begin
        if (!stat.char_token) begin
          cmd.absorb = 1'b1;
          state_nxt  = stat.end_seen ? S_END_CLOSE : S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_char = 1'b1;
          state_nxt     = stat.end_seen ? S_END_CLOSE : S_IDLE;
        end
      end
      S_END_CLOSE: begin
        if (!stat.run_open) begin
          state_nxt = S_EVAL;
        end else if (stat.out_free) begin
          cmd.emit_run = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.need_div ? S_DIV : S_ANS;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_ANS;
        end
      end
      S_ANS: begin
        if (stat.out_free) begin
          cmd.emit_ans = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/char_tokenizer_with_binary_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_tokenizer_with_binary_eval_core
// character tokenizer with a one-operator expression evaluator
//
//   channel | dir | tdata                   | tuser | tlast
//   --------+-----+-------------------------+-------+-------------
//   in_     | in  | char_code               | -     | end_of_text
//   out_    | out | num..error_flag (136 b) | kind  | last_out
//
// a character passes the sequencer states take, close run and body in turn;
// the tokens it sends go into the output register in those states
// the last character of an expression then passes the states that close the
// open run, evaluate and send the answer, with a wait for the divider when
// the answer is a division (one quotient bit per cycle in the divider)
// rst_n is synchronous and active low; it drops any result held and any run
// a result waits in the output register while the next character is taken;
// apart from the divider wait, the sequencer only stalls when a second result would overwrite it
// ----------------------------------------------------------------------------
module char_tokenizer_with_binary_eval_core
  import cte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // input characters
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_code
  input  logic                  in_tlast,   // end_of_text

  // tokens and answer
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] num_value, [95:32] text_chars, [99:96] text_len,
  // [131:100] answer, [132] error_flag, [135:133] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser,  // [2:0] kind
  output logic                  out_tlast   // last_out
);

  // command and status between sequencer and datapath
  cte_cmd_t  cmd;
  cte_stat_t stat;

  // result fields from the output register
  logic [KIND_W-1:0] res_kind;
  logic [NUM_W-1:0]  res_num;
  logic [TEXT_W-1:0] res_text;
  logic [LEN_W-1:0]  res_len;
  logic [NUM_W-1:0]  res_answer;
  logic              res_err;

  cte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cte_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (in_tdata),
    .in_end     (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (res_kind),
    .out_num    (res_num),
    .out_text   (res_text),
    .out_len    (res_len),
    .out_answer (res_answer),
    .out_err    (res_err),
    .out_last   (out_tlast)
  );

  // pack the result fields, first field in the low bits
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_err, res_answer, res_len, res_text, res_num};
  assign out_tuser = res_kind;

endmodule
